[rtl/core/section_bias_crossfade_defines.svh]
// assertion macros for the section bias crossfade block
`ifndef SECTION_BIAS_CROSSFADE_DEFINES_SVH
`define SECTION_BIAS_CROSSFADE_DEFINES_SVH

`ifndef SYNTHESIS
`define SBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("section_bias_crossfade: assertion failed");
`define SBC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("section_bias_crossfade: reset assertion failed");
`else
`define SBC_ASSERT(lbl, prop)
`define SBC_ASSERT_RST(lbl, prop)
`endif

`endif

[rtl/core/sbc_pkg.sv]
// types, section tables and constants for the section bias crossfade block
`default_nettype none

package sbc_pkg;

  localparam int NUM_SECTIONS = 4;
  localparam int NUM_BIAS     = 4;
  localparam int FULL_WEIGHT  = 256;
  localparam int BAR_W        = 32;
  localparam int OUT_W        = 40;

  localparam int IDX_GATE     = 0;
  localparam int IDX_CUTOFF   = 1;
  localparam int IDX_REVERB   = 2;
  localparam int IDX_MUTATION = 3;

  typedef logic [1:0]        sec_t;
  typedef logic signed [7:0] bias_t;
  typedef logic [7:0]        weight_t;
  typedef logic signed [8:0] bias_diff_t;

  typedef enum logic [1:0] {
    FADE_NONE,
    FADE_IN,
    FADE_OUT
  } fade_mode_t;

  localparam bias_t BIAS_TBL [NUM_BIAS][NUM_SECTIONS] = '{
    '{-8'sd64,  8'sd0,  8'sd32, -8'sd16},
    '{-8'sd40,  8'sd0,  8'sd30, -8'sd10},
    '{ 8'sd40,  8'sd0, -8'sd20,  8'sd20},
    '{ 8'sd8,   8'sd0, -8'sd4,   8'sd4 }
  };

  localparam logic [1:0] KICK_TBL   [NUM_SECTIONS] = '{2'd0, 2'd0, 2'd2, 2'd0};
  localparam logic [1:0] MELODY_TBL [NUM_SECTIONS] = '{2'd2, 2'd0, 2'd1, 2'd0};
  localparam logic       ARP_TBL    [NUM_SECTIONS] = '{1'b0, 1'b0, 1'b1, 1'b0};

endpackage

`default_nettype wire

[rtl/core/section_bias_crossfade.sv]
// section lookup with crossfaded biases: six-stage streaming pipeline
// each input is registered in every stage, from bar_r to out_r, before it is valid at the output
// throughput: one item per cycle while out_tready is high; each stage moves on when the next is free
// the bar is reduced modulo the period in three stages (byte residues,
// reciprocal multiply, remainder with correction), then lookup and blend
// reset: synchronous active-low rst_n clears all stage valid flags
`default_nettype none
`include "section_bias_crossfade_defines.svh"

module section_bias_crossfade #(
  parameter int SECTION_LENGTH = 24,
  parameter int FADE_LENGTH    = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sbc_pkg::BAR_W-1:0]   in_tdata,   // [31:0] bar
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [1:0] section_index, [9:2] gate_bias, [17:10] cutoff_bias,
  // [25:18] reverb_bias, [33:26] mutation_bias, [35:34] kick_sel,
  // [37:36] melody_character, [38] arpeggio_on, [39] zero
  output logic [sbc_pkg::OUT_W-1:0]   out_tdata
);
  import sbc_pkg::*;

  localparam int HALF     = FADE_LENGTH / 2;
  localparam int SPAN     = 2 * HALF;
  localparam int CYC_BARS = NUM_SECTIONS * SECTION_LENGTH;
  localparam int CW       = $clog2(CYC_BARS);
  localparam int LW       = $clog2(SECTION_LENGTH);
  localparam int PW       = CW + 10;
  localparam int MW       = PW + 1;
  localparam int SH       = PW + CW;
  localparam int XW       = PW + MW;
  localparam int QW       = XW - SH;
  localparam longint unsigned RECIP = (longint'(1) << SH) / CYC_BARS;
  localparam int RES1     = 256 % CYC_BARS;
  localparam int RES2     = 65536 % CYC_BARS;
  localparam int RES3     = 16777216 % CYC_BARS;
  localparam int NSTAGE   = 6;

  // per-position fade tables, worked out at elaboration
  function automatic weight_t weight_at(input int p);
    weight_at = '0;
    if (p < HALF) begin
      weight_at = weight_t'((p + HALF) * FULL_WEIGHT / SPAN);
    end else if (p + HALF >= SECTION_LENGTH) begin
      weight_at = weight_t'((p + HALF - SECTION_LENGTH) * FULL_WEIGHT / SPAN);
    end
  endfunction

  function automatic fade_mode_t mode_at(input int p);
    mode_at = FADE_NONE;
    if (p < HALF) begin
      mode_at = FADE_IN;
    end else if (p + HALF >= SECTION_LENGTH) begin
      mode_at = FADE_OUT;
    end
  endfunction

  weight_t    wtab [SECTION_LENGTH];
  fade_mode_t mtab [SECTION_LENGTH];

  for (genvar gi = 0; gi < SECTION_LENGTH; gi++) begin : g_tab
    assign wtab[gi] = weight_at(gi);
    assign mtab[gi] = mode_at(gi);
  end

  // stage flow control
  logic [NSTAGE-1:0] v_r, v_nxt;
  logic [NSTAGE-1:0] ld;

  always_comb begin
    ld[NSTAGE-1] = !v_r[NSTAGE-1] || out_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
    v_nxt[0] = ld[0] ? in_tvalid : v_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      v_nxt[k] = ld[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = ld[0];
  assign out_tvalid = v_r[NSTAGE-1];

  // stage 0: input register
  logic [BAR_W-1:0] bar_r;

  // stage 1: sum of byte residues, congruent to bar modulo the period
  logic [PW-1:0] part_r, part_nxt;
  assign part_nxt = PW'(bar_r[7:0])
                  + PW'(bar_r[15:8])  * PW'(RES1)
                  + PW'(bar_r[23:16]) * PW'(RES2)
                  + PW'(bar_r[31:24]) * PW'(RES3);

  // stage 2: reciprocal product
  logic [XW-1:0] prod_r, prod_nxt;
  logic [PW-1:0] x_r;
  assign prod_nxt = XW'(part_r) * XW'(RECIP);

  // stage 3: remainder, quotient may come out one short
  logic [QW-1:0] quo;
  logic [PW-1:0] rem;
  logic [CW-1:0] cyc_r, cyc_nxt;

  always_comb begin
    quo = prod_r[XW-1:SH];
    rem = x_r - PW'(quo) * PW'(CYC_BARS);
    if (rem >= PW'(CYC_BARS)) begin
      rem = rem - PW'(CYC_BARS);
    end
    cyc_nxt = rem[CW-1:0];
  end

  // stage 4: section, position and blend operands
  sec_t       sec_nxt, sec_r, sec_prev, sec_next;
  logic [CW-1:0] base;
  logic [CW-1:0] pos_full;
  logic [LW-1:0] pos;
  fade_mode_t mode;
  weight_t    w_nxt, w_r;
  bias_t      a_nxt [NUM_BIAS];
  bias_t      a_r   [NUM_BIAS];
  bias_t      b_sel [NUM_BIAS];
  bias_t      cur   [NUM_BIAS];
  bias_diff_t d_nxt [NUM_BIAS];
  bias_diff_t d_r   [NUM_BIAS];

  always_comb begin
    if (cyc_r >= CW'(3 * SECTION_LENGTH)) begin
      sec_nxt = 2'd3;
      base    = CW'(3 * SECTION_LENGTH);
    end else if (cyc_r >= CW'(2 * SECTION_LENGTH)) begin
      sec_nxt = 2'd2;
      base    = CW'(2 * SECTION_LENGTH);
    end else if (cyc_r >= CW'(SECTION_LENGTH)) begin
      sec_nxt = 2'd1;
      base    = CW'(SECTION_LENGTH);
    end else begin
      sec_nxt = 2'd0;
      base    = '0;
    end
    pos_full = cyc_r - base;
    pos      = pos_full[LW-1:0];
    mode     = mtab[pos];
    w_nxt    = wtab[pos];
    sec_prev = sec_nxt - 2'd1;
    sec_next = sec_nxt + 2'd1;
    for (int j = 0; j < NUM_BIAS; j++) begin
      cur[j] = BIAS_TBL[j][sec_nxt];
      case (mode)
        FADE_IN: begin
          a_nxt[j] = BIAS_TBL[j][sec_prev];
          b_sel[j] = cur[j];
        end
        FADE_OUT: begin
          a_nxt[j] = cur[j];
          b_sel[j] = BIAS_TBL[j][sec_next];
        end
        default: begin
          a_nxt[j] = cur[j];
          b_sel[j] = cur[j];
        end
      endcase
      d_nxt[j] = 9'(b_sel[j]) - 9'(a_nxt[j]);
    end
  end

  // stage 5: a*256 + (b-a)*w, floor shift by 8, low byte kept
  logic signed [17:0] mix  [NUM_BIAS];
  bias_t              res  [NUM_BIAS];
  logic [OUT_W-1:0]   out_r, out_nxt;

  always_comb begin
    for (int j = 0; j < NUM_BIAS; j++) begin
      mix[j] = (18'(a_r[j]) <<< 8) + 18'(d_r[j]) * 18'($signed({1'b0, w_r}));
      res[j] = mix[j][15:8];
    end
    out_nxt = {1'b0, ARP_TBL[sec_r], MELODY_TBL[sec_r], KICK_TBL[sec_r],
               res[IDX_MUTATION], res[IDX_REVERB], res[IDX_CUTOFF],
               res[IDX_GATE], sec_r};
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      bar_r <= in_tdata;
    end
    if (ld[1]) begin
      part_r <= part_nxt;
    end
    if (ld[2]) begin
      prod_r <= prod_nxt;
      x_r    <= part_r;
    end
    if (ld[3]) begin
      cyc_r <= cyc_nxt;
    end
    if (ld[4]) begin
      sec_r <= sec_nxt;
      w_r   <= w_nxt;
      a_r   <= a_nxt;
      d_r   <= d_nxt;
    end
    if (ld[5]) begin
      out_r <= out_nxt;
    end
  end

  assign out_tdata = out_r;

  `SBC_ASSERT_RST(a_rst_clear, (!rst_n) |=> (v_r == '0))
  `SBC_ASSERT(a_accept_s0, (in_tvalid && in_tready) |=> v_r[0])
  `SBC_ASSERT(a_cyc_range, v_r[3] |-> ({1'b0, cyc_r} < (CW + 1)'(CYC_BARS)))
  `SBC_ASSERT(a_hold_s4, (v_r[4] && !ld[4]) |=> (v_r[4] && $stable(w_r)))

endmodule

`default_nettype wire
